### rtl/core/jhsd_pkg.sv
package jhsd_pkg;

  localparam logic [2:0] ACT_FEED   = 3'd0;
  localparam logic [2:0] ACT_TABLE  = 3'd1;
  localparam logic [2:0] ACT_DECODE = 3'd2;
  localparam logic [2:0] ACT_BITS   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_STARVED  = 4'd1;
  localparam logic [3:0] ST_FULL     = 4'd2;
  localparam logic [3:0] ST_FFFF     = 4'd3;
  localparam logic [3:0] ST_RESTART  = 4'd4;
  localparam logic [3:0] ST_MARKER   = 4'd5;
  localparam logic [3:0] ST_BAD_ID   = 4'd6;
  localparam logic [3:0] ST_INVALID  = 4'd7;
  localparam logic [3:0] ST_OVERFLOW = 4'd8;

  typedef struct packed {
    logic latch;
    logic exec;
    logic dec_init;
    logic dec_shift;
    logic dec_starve;
    logic dec_hit;
    logic dec_advance;
    logic dec_invalid;
    logic sym_done;
  } jhsd_cmd_t;

  typedef struct packed {
    logic is_decode;
    logic starved;
    logic hit;
    logic overflow;
    logic last_len;
  } jhsd_stat_t;

endpackage

### rtl/core/jhsd_ram.sv
module jhsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/jhsd_ctrl.sv
module jhsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  jhsd_pkg::jhsd_stat_t stat,
  output jhsd_pkg::jhsd_cmd_t  cmd,
  output logic                busy
);
  import jhsd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DRD, S_DCMP, S_SYM} state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_decode) begin
          cmd.dec_init = 1'b1;
          state_next = S_DRD;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DRD: begin
        if (stat.starved) begin
          cmd.dec_starve = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.dec_shift = 1'b1;
          state_next = S_DCMP;
        end
      end
      S_DCMP: begin
        if (stat.hit) begin
          cmd.dec_hit = 1'b1;
          state_next = stat.overflow ? S_IDLE : S_SYM;
        end else if (stat.last_len) begin
          cmd.dec_invalid = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.dec_advance = 1'b1;
          state_next = S_DRD;
        end
      end
      S_SYM: begin
        cmd.sym_done = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/core/jhsd_datapath.sv
module jhsd_datapath #(
  parameter int AC_CAPACITY     = 162,
  parameter int DC_CAPACITY     = 14,
  parameter int MAX_CODE_LENGTH = 16,
  parameter int BUFFER_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           action,
  input  logic [7:0]           data_byte,
  input  logic [1:0]           table_select,
  input  logic [5:0]           bit_request,
  input  jhsd_pkg::jhsd_cmd_t  cmd,
  output jhsd_pkg::jhsd_stat_t stat,
  output logic                 done,
  output logic [31:0]          value,
  output logic [3:0]           status
);
  import jhsd_pkg::*;

  localparam int FILL_W    = $clog2(BUFFER_BITS + 1);
  localparam int LEN_W     = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
  localparam int CODE_W    = MAX_CODE_LENGTH;
  localparam int CODE_AW   = LEN_W + 2;
  localparam int CODE_DEPTH = 1 << CODE_AW;
  localparam int SYM_DEPTH = 2 * (DC_CAPACITY + AC_CAPACITY);
  localparam int SYM_AW    = $clog2(SYM_DEPTH);

  typedef enum logic [1:0] {PH_HEADER, PH_COUNTS, PH_SYMBOLS} phase_t;

  function automatic logic [8:0] cap(input logic [1:0] t);
    return t[1] ? 9'(AC_CAPACITY) : 9'(DC_CAPACITY);
  endfunction

  function automatic logic [SYM_AW-1:0] base(input logic [1:0] t);
    logic [SYM_AW-1:0] b;
    case (t)
      2'd0:    b = '0;
      2'd1:    b = SYM_AW'(DC_CAPACITY);
      2'd2:    b = SYM_AW'(2 * DC_CAPACITY);
      default: b = SYM_AW'(2 * DC_CAPACITY + AC_CAPACITY);
    endcase
    return b;
  endfunction

  logic [2:0]             act_q;
  logic [7:0]             byte_q;
  logic [1:0]             sel_q;
  logic [5:0]             req_q;
  logic [BUFFER_BITS-1:0] bit_buffer;
  logic [FILL_W-1:0]      bit_fill;
  logic                   pending_ff;
  phase_t                 load_phase;
  logic [1:0]             load_table;
  logic [11:0]            load_index;
  logic [16:0]            running_code;
  logic [11:0]            leaves_total;
  logic [LEN_W-1:0]       len;
  logic [CODE_W-1:0]      code;

  // code table entry: min, max, value offset
  logic                   code_we;
  logic [CODE_AW-1:0]     code_waddr;
  logic [47:0]            code_wdata;
  logic [47:0]            code_rdata;
  logic [17:0]            rd_min;
  logic [17:0]            rd_max;
  logic [11:0]            rd_off;
  logic                   sym_we;
  logic [SYM_AW-1:0]      sym_waddr;
  logic [SYM_AW-1:0]      sym_raddr;
  logic [7:0]             sym_rdata;

  logic [17:0]            mn2;
  logic [16:0]            mn;
  logic [17:0]            run_sum;
  logic [16:0]            run_new;
  logic [17:0]            max_new;
  logic [11:0]            leaves_new;
  logic [11:0]            index_inc;

  logic [FILL_W-1:0]      pos;
  logic [BUFFER_BITS-1:0] shifted;
  logic                   new_bit;
  logic signed [19:0]     idx;
  logic [5:0]             nbits;
  logic [31:0]            bits_val;
  logic                   bits_starved;
  logic                   feed_full;
  logic [FILL_W-1:0]      drop_n;
  logic [FILL_W-1:0]      fill_after;
  logic [BUFFER_BITS-1:0] buf_after;
  logic [7:0]             push_val;

  jhsd_ram #(.WIDTH(48), .DEPTH(CODE_DEPTH)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (code_waddr),
    .wdata (code_wdata),
    .raddr ({sel_q, len}),
    .rdata (code_rdata)
  );

  jhsd_ram #(.WIDTH(8), .DEPTH(SYM_DEPTH)) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (byte_q),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  assign rd_min = code_rdata[47:30];
  assign rd_max = code_rdata[29:12];
  assign rd_off = code_rdata[11:0];

  // table loader
  always_comb begin
    mn2 = {running_code, 1'b0};
    mn = mn2[17] ? 17'h1FFFF : mn2[16:0];
    run_sum = 18'(mn) + 18'(byte_q);
    run_new = run_sum[17] ? 17'h1FFFF : run_sum[16:0];
    max_new = (byte_q != 8'd0) ? (18'(run_new) - 18'd1) : '1;
    leaves_new = leaves_total + 12'(byte_q);
    index_inc = load_index + 12'd1;
    code_we = cmd.exec && (act_q == ACT_TABLE) && (load_phase == PH_COUNTS);
    code_waddr = {load_table, load_index[LEN_W-1:0]};
    code_wdata = {18'(mn), max_new, leaves_total};
    sym_we = cmd.exec && (act_q == ACT_TABLE) && (load_phase == PH_SYMBOLS)
             && (load_index < 12'(cap(load_table)));
    sym_waddr = SYM_AW'(base(load_table)) + SYM_AW'(load_index);
  end

  // decode step
  always_comb begin
    pos = bit_fill - FILL_W'(1) - FILL_W'(len);
    shifted = bit_buffer >> pos;
    new_bit = shifted[0];
    stat.is_decode = (act_q == ACT_DECODE);
    stat.starved = ((FILL_W + 1)'(len) + (FILL_W + 1)'(1)) > {1'b0, bit_fill};
    stat.hit = !rd_max[17] && (18'(code) <= rd_max);
    idx = $signed(20'(rd_off)) + $signed(20'(code)) - $signed(20'(rd_min));
    stat.overflow = idx[19] || (idx[18:0] >= 19'(cap(sel_q)));
    stat.last_len = (len == LEN_W'(MAX_CODE_LENGTH - 1));
    sym_raddr = SYM_AW'(base(sel_q)) + SYM_AW'(idx[18:0]);
  end

  // raw bits, bit drop and byte push
  always_comb begin
    nbits = (req_q > 6'd32) ? 6'd32 : req_q;
    bits_starved = (FILL_W + 1)'(nbits) > {1'b0, bit_fill};
    bits_val = 32'((bit_buffer >> (bit_fill - FILL_W'(nbits)))
                   & ~({BUFFER_BITS{1'b1}} << nbits));
    feed_full = ((FILL_W + 1)'(bit_fill) + (FILL_W + 1)'(8)) > (FILL_W + 1)'(BUFFER_BITS);
    push_val = pending_ff ? 8'hFF : byte_q;
    drop_n = '0;
    if (cmd.dec_hit) begin
      drop_n = FILL_W'(len) + FILL_W'(1);
    end else if (cmd.dec_invalid) begin
      drop_n = FILL_W'(MAX_CODE_LENGTH);
    end else if (act_q == ACT_BITS) begin
      drop_n = FILL_W'(nbits);
    end else begin
      drop_n = FILL_W'(bit_fill[2:0]);
    end
    fill_after = bit_fill - drop_n;
    buf_after = bit_buffer & ~({BUFFER_BITS{1'b1}} << fill_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      bit_buffer <= '0;
      bit_fill <= '0;
      pending_ff <= 1'b0;
      load_phase <= PH_HEADER;
      load_table <= '0;
      load_index <= '0;
      running_code <= '0;
      leaves_total <= '0;
      len <= '0;
      code <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.latch) begin
        act_q <= action;
        byte_q <= data_byte;
        sel_q <= table_select;
        req_q <= bit_request;
      end
      if (cmd.exec) begin
        done <= 1'b1;
        value <= '0;
        status <= ST_OK;
        case (act_q)
          ACT_FEED: begin
            if (pending_ff) begin
              pending_ff <= 1'b0;
              if (byte_q == 8'h00) begin
                bit_buffer <= BUFFER_BITS'({bit_buffer, push_val});
                bit_fill <= bit_fill + FILL_W'(8);
              end else if (byte_q == 8'hFF) begin
                status <= ST_FFFF;
              end else if (byte_q[7:3] == 5'b11010) begin
                status <= ST_RESTART;
              end else begin
                status <= ST_MARKER;
              end
            end else if (feed_full) begin
              status <= ST_FULL;
            end else if (byte_q == 8'hFF) begin
              pending_ff <= 1'b1;
            end else begin
              bit_buffer <= BUFFER_BITS'({bit_buffer, push_val});
              bit_fill <= bit_fill + FILL_W'(8);
            end
          end
          ACT_TABLE: begin
            case (load_phase)
              PH_HEADER: begin
                if (byte_q[3:0] > 4'd1) begin
                  status <= ST_BAD_ID;
                end else begin
                  load_table <= {byte_q[7:4] != 4'd0, byte_q[0]};
                  load_phase <= PH_COUNTS;
                  load_index <= '0;
                  running_code <= '0;
                  leaves_total <= '0;
                end
              end
              PH_COUNTS: begin
                running_code <= run_new;
                leaves_total <= leaves_new;
                if (index_inc >= 12'(MAX_CODE_LENGTH)) begin
                  load_index <= '0;
                  load_phase <= (leaves_new != 12'd0) ? PH_SYMBOLS : PH_HEADER;
                end else begin
                  load_index <= index_inc;
                end
              end
              default: begin
                if (index_inc >= leaves_total) begin
                  load_index <= '0;
                  load_phase <= PH_HEADER;
                end else begin
                  load_index <= index_inc;
                end
              end
            endcase
          end
          ACT_BITS: begin
            if (bits_starved) begin
              status <= ST_STARVED;
            end else begin
              value <= (nbits == 6'd0) ? 32'd0 : bits_val;
              bit_fill <= fill_after;
              bit_buffer <= buf_after;
            end
          end
          ACT_CLEAR: begin
            bit_fill <= fill_after;
            bit_buffer <= buf_after;
          end
          default: begin
          end
        endcase
      end
      if (cmd.dec_init) begin
        len <= '0;
        code <= '0;
      end
      if (cmd.dec_shift) begin
        code <= CODE_W'({code, new_bit});
      end
      if (cmd.dec_advance) begin
        len <= len + LEN_W'(1);
      end
      if (cmd.dec_starve) begin
        done <= 1'b1;
        value <= '0;
        status <= ST_STARVED;
      end
      if (cmd.dec_hit || cmd.dec_invalid) begin
        bit_fill <= fill_after;
        bit_buffer <= buf_after;
      end
      if (cmd.dec_hit && stat.overflow) begin
        done <= 1'b1;
        value <= '0;
        status <= ST_OVERFLOW;
      end
      if (cmd.dec_invalid) begin
        done <= 1'b1;
        value <= '0;
        status <= ST_INVALID;
      end
      if (cmd.sym_done) begin
        done <= 1'b1;
        value <= 32'(sym_rdata);
        status <= ST_OK;
      end
    end
  end

endmodule

### rtl/core/jpeg_huffman_symbol_decoder_unit.sv
// channel  | handshake           | payload
// request  | start, busy         | action, data_byte, table_select, bit_request
// result   | done (one cycle)    | value, status
//
// stream, table, bit and clear requests are latched, then executed in the exec state
// a symbol decode runs the read and compare states once per code length tried, then
// the symbol read state on an in-range hit; each length costs one code table read
// one request at a time: busy stays high until the result strobe is issued
// synchronous reset clears the bit buffer and loader; table memories are not cleared
// done lasts one cycle and cannot be stalled
module jpeg_huffman_symbol_decoder_unit #(
  parameter int AC_CAPACITY     = 162,
  parameter int DC_CAPACITY     = 14,
  parameter int MAX_CODE_LENGTH = 16,
  parameter int BUFFER_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  table_select,
  input  logic [5:0]  bit_request,
  output logic        busy,
  output logic        done,
  output logic [31:0] value,
  output logic [3:0]  status
);
  import jhsd_pkg::*;

  jhsd_cmd_t  cmd;
  jhsd_stat_t stat;

  jhsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  jhsd_datapath #(
    .AC_CAPACITY     (AC_CAPACITY),
    .DC_CAPACITY     (DC_CAPACITY),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .BUFFER_BITS     (BUFFER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .data_byte    (data_byte),
    .table_select (table_select),
    .bit_request  (bit_request),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .value        (value),
    .status       (status)
  );

endmodule

### rtl/core/jhsd_checker.sv
module jhsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] value,
  input logic [3:0]  status
);
  import jhsd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transfer did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in flight");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results back to back");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> value == 32'd0) else $error("value set on error");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_OVERFLOW) else $error("status out of range");

endmodule

bind jpeg_huffman_symbol_decoder_unit jhsd_checker u_jhsd_checker (.*);
